>>> src/rob_pkg.sv
// Shared types, constants and helpers of the oriented box nearest hit core.
`default_nettype none
package rob_pkg;

  localparam int WORDS_PER_BOX = 24;
  localparam int FWD_OFFSET    = 12;
  localparam int REG_BOX_COUNT = 0;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_XI   = 13'b0000000000010,
    S_SL   = 13'b0000000000100,
    S_TEST = 13'b0000000001000,
    S_HIT  = 13'b0000000010000,
    S_XF   = 13'b0000000100000,
    S_SQ   = 13'b0000001000000,
    S_CMP  = 13'b0000010000000,
    S_NRM  = 13'b0000100000000,
    S_SQRT = 13'b0001000000000,
    S_DIVN = 13'b0010000000000,
    S_NEXT = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(x[31:0]);
    end
  endfunction

endpackage
`default_nettype wire

>>> src/rob_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rob_ram #(
  parameter int W = 32,
  parameter int D = 1536
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/rob_div.sv
// Bit-serial signed divider, quotient truncated toward zero.
`default_nettype none
module rob_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic signed [33:0] divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);

  logic [63:0] quo_r;
  logic [33:0] rem_r;
  logic [33:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        neg_r;
  logic [34:0] trial;

  assign trial    = {rem_r, quo_r[63]};
  assign done     = done_r;
  assign quotient = neg_r ? -signed'(quo_r) : signed'(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        dvs_r  <= divisor[33] ? 34'(-divisor) : 34'(divisor);
        neg_r  <= dividend[63] ^ divisor[33];
        rem_r  <= '0;
        cnt_r  <= 7'd64;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= 34'(trial - {1'b0, dvs_r});
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= trial[33:0];
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/rob_isqrt.sv
// Iterative integer square root (floor) of a 64-bit value.
`default_nettype none
module rob_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] cand;

  assign cand = res_r + bit_r;
  assign done = done_r;
  assign root = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= value;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        cnt_r  <= 6'd32;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= cand) begin
          v_r   <= v_r - cand;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/ray_oriented_box_nearest_hit_core.sv
// Top level: ray against oriented boxes, nearest hit position and normal.
//
// channel | dir | handshake              | word
// in_     | in  | in_valid / in_ready    | load transform word or cast ray
// out_    | out | out_valid / out_ready  | hit flag, position, normal
// cfg_    | in  | psel/penable/pwrite    | box_count register
//
// How long a ray takes depends on the boxes tested and which of them hit and
// are nearest so far; the bit-serial divider (up to three reciprocals and
// three normal components per box) sets most of it. The transform RAM has
// no reset; boxes must be loaded before use. Input is taken only when idle;
// a finished result waits in the output register while the next word enters.
`default_nettype none
module ray_oriented_box_nearest_hit_core #(
  parameter int NUM_BOXES = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [0:0]         in_mode,
  input  wire logic [5:0]         in_box_index,
  input  wire logic [4:0]         in_word_index,
  input  wire logic signed [31:0] in_word_value,
  input  wire logic signed [31:0] in_ray_start_x,
  input  wire logic signed [31:0] in_ray_start_y,
  input  wire logic signed [31:0] in_ray_start_z,
  input  wire logic signed [17:0] in_ray_dir_x,
  input  wire logic signed [17:0] in_ray_dir_y,
  input  wire logic signed [17:0] in_ray_dir_z,
  input  wire logic [30:0]        in_ray_length,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [0:0]              out_any_hit,
  output logic signed [31:0]      out_hit_pos_x,
  output logic signed [31:0]      out_hit_pos_y,
  output logic signed [31:0]      out_hit_pos_z,
  output logic signed [17:0]      out_hit_norm_x,
  output logic signed [17:0]      out_hit_norm_y,
  output logic signed [17:0]      out_hit_norm_z,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import rob_pkg::*;

  localparam int DEPTH = NUM_BOXES * WORDS_PER_BOX;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(NUM_BOXES + 1);
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] EPS_Q =
    ((64'sd1 <<< FRAC_BITS) + 64'sd50000) / 64'sd100000;
  localparam logic signed [63:0] RECIP_NUM = 64'sd1 <<< (2 * FRAC_BITS);

  state_t             state_r;
  logic [2:0]         ph_r;
  logic [1:0]         k_r;
  logic [1:0]         c_r;
  logic [1:0]         ax_r;
  logic [6:0]         box_count_r;
  logic [BW-1:0]      n_r;
  logic [BW-1:0]      b_r;
  logic [AW-1:0]      base_r;
  logic signed [31:0] rs_r [3];
  logic signed [17:0] rd_r [3];
  logic [30:0]        len_r;
  logic signed [31:0] ls_r [3];
  logic signed [31:0] ld_r [3];
  logic signed [31:0] lh_r [3];
  logic signed [31:0] wp_r [3];
  logic signed [63:0] tn_r [3];
  logic signed [63:0] tf_r [3];
  logic signed [63:0] ta_r;
  logic signed [63:0] tmin_r;
  logic signed [63:0] acc_s_r;
  logic signed [63:0] acc_d_r;
  logic signed [31:0] word_r;
  logic signed [31:0] inv_r;
  logic [63:0]        sq_r;
  logic [63:0]        best_sq_r;
  logic [63:0]        s2_r;
  logic [31:0]        mag_r;
  logic signed [32:0] v_r [3];
  logic               hit_r;
  logic signed [31:0] best_pos_r [3];
  logic signed [17:0] best_nrm_r [3];
  logic signed [67:0] prod_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic signed [31:0] out_pos_r [3];
  logic signed [17:0] out_nrm_r [3];

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod_sh;
  logic signed [63:0] prod_q;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic               div_start;
  logic signed [63:0] div_dvd;
  logic signed [33:0] div_dvs;
  logic               div_done;
  logic signed [63:0] div_quo;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic [BW-1:0]      n_eff;
  logic signed [32:0] sq_diff;
  logic [32:0]        sq_mag;
  logic [32:0]        v_mag;
  logic signed [63:0] tmin1;
  logic signed [63:0] tmax1;
  logic signed [63:0] tmin2;
  logic               slab_hit;
  logic [1:0]         ax_sel;
  logic signed [63:0] q_nrm;
  logic signed [32:0] col_v;
  logic signed [63:0] q_clamp;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_any_hit    = out_hit_r;
  assign out_hit_pos_x  = out_pos_r[0];
  assign out_hit_pos_y  = out_pos_r[1];
  assign out_hit_pos_z  = out_pos_r[2];
  assign out_hit_norm_x = out_nrm_r[0];
  assign out_hit_norm_y = out_nrm_r[1];
  assign out_hit_norm_z = out_nrm_r[2];
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == 1'b0) ? 32'(box_count_r) : 32'd0;

  assign we = in_valid && in_ready && (in_mode == 1'b0) &&
              (32'(in_box_index) < NUM_BOXES) &&
              (32'(in_word_index) < WORDS_PER_BOX);
  assign waddr = AW'(32'(in_box_index) * WORDS_PER_BOX + 32'(in_word_index));

  assign n_eff = (32'(box_count_r) > NUM_BOXES) ? BW'(NUM_BOXES) : BW'(box_count_r);

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign prod_q  = signed'(prod_sh[63:0]);

  assign sq_diff = 33'(wp_r[k_r]) - 33'(rs_r[k_r]);
  assign sq_mag  = sq_diff[32] ? 33'(-sq_diff) : 33'(sq_diff);
  assign v_mag   = v_r[k_r][32] ? 33'(-v_r[k_r]) : 33'(v_r[k_r]);
  assign col_v   = (ld_r[ax_r] < 0) ? 33'(signed'(rdata)) : -33'(signed'(rdata));

  assign tmin1 = (tn_r[0] > tn_r[1]) ? tn_r[0] : tn_r[1];
  assign tmax1 = (tf_r[0] < tf_r[1]) ? tf_r[0] : tf_r[1];
  assign tmin2 = (tn_r[2] > tmin1) ? tn_r[2] : tmin1;
  assign slab_hit = !(tn_r[0] > tf_r[1] || tn_r[1] > tf_r[0]) &&
                    !(tmin1 > tf_r[2] || tn_r[2] > tmax1) &&
                    (EPS_Q < tmin2) && (tmin2 < signed'({33'd0, len_r}));
  assign ax_sel = (tn_r[0] > tn_r[1] && tn_r[0] > tn_r[2]) ? 2'd0 :
                  (tn_r[1] > tn_r[2]) ? 2'd1 : 2'd2;

  assign q_nrm   = div_quo;
  assign q_clamp = (q_nrm > ONE_Q) ? ONE_Q : ((q_nrm < -ONE_Q) ? -ONE_Q : q_nrm);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_XI: begin
        mul_a = 34'(word_r);
        if (ph_r == 3'd3) begin
          mul_b = 34'(rd_r[c_r]);
        end else begin
          mul_b = 34'(rs_r[c_r]);
        end
      end
      S_SL: begin
        mul_b = 34'(inv_r);
        if (ph_r == 3'd3) begin
          mul_a = 34'(ONE_Q - 64'(ls_r[k_r]));
        end else begin
          mul_a = 34'(-ONE_Q - 64'(ls_r[k_r]));
        end
      end
      S_HIT: begin
        mul_a = 34'(ld_r[k_r]);
        mul_b = signed'(tmin_r[33:0]);
      end
      S_XF: begin
        mul_a = 34'(word_r);
        mul_b = 34'(lh_r[c_r]);
      end
      S_SQ: begin
        mul_a = signed'({1'b0, sq_mag});
        mul_b = signed'({1'b0, sq_mag});
      end
      S_NRM: begin
        mul_a = signed'({1'b0, v_mag});
        mul_b = signed'({1'b0, v_mag});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_XI:    raddr = AW'(base_r + AW'({k_r, c_r}));
      S_XF:    raddr = AW'(base_r + AW'(FWD_OFFSET) + AW'({k_r, c_r}));
      S_NRM:   raddr = AW'(base_r + AW'(FWD_OFFSET) + AW'({k_r, 2'b00}) + AW'(ax_r));
      default: raddr = base_r;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = RECIP_NUM;
    div_dvs   = 34'(ld_r[k_r]);
    if (state_r == S_SL) begin
      div_start = (ph_r == 3'd0) && (ld_r[k_r] != 0);
    end else if (state_r == S_DIVN) begin
      div_start = (ph_r == 3'd0);
      div_dvd   = 64'(v_r[k_r]) <<< FRAC_BITS;
      div_dvs   = signed'({2'b00, mag_r});
    end
  end

  assign sqrt_start = (state_r == S_SQRT) && (ph_r == 3'd0);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      box_count_r <= '0;
      ph_r        <= '0;
      k_r         <= '0;
      c_r         <= '0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
        box_count_r <= pwdata[6:0];
      end
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_mode == 1'b1) begin
            rs_r[0] <= in_ray_start_x;
            rs_r[1] <= in_ray_start_y;
            rs_r[2] <= in_ray_start_z;
            rd_r[0] <= in_ray_dir_x;
            rd_r[1] <= in_ray_dir_y;
            rd_r[2] <= in_ray_dir_z;
            len_r   <= in_ray_length;
            n_r     <= n_eff;
            b_r     <= '0;
            base_r  <= '0;
            hit_r   <= 1'b0;
            best_sq_r <= '1;
            acc_s_r <= '0;
            acc_d_r <= '0;
            ph_r    <= '0;
            k_r     <= '0;
            c_r     <= '0;
            for (int i = 0; i < 3; i++) begin
              best_pos_r[i] <= '0;
              best_nrm_r[i] <= '0;
            end
            state_r <= (n_eff == '0) ? S_DONE : S_XI;
          end
        end
        S_XI: begin
          unique case (ph_r)
            3'd0: ph_r <= 3'd1;
            3'd1: begin
              word_r <= signed'(rdata);
              ph_r   <= 3'd2;
            end
            3'd2: begin
              if (c_r == 2'd3) begin
                ls_r[k_r] <= sat32(acc_s_r + 64'(word_r));
                ld_r[k_r] <= sat32(acc_d_r);
                acc_s_r   <= '0;
                acc_d_r   <= '0;
                c_r       <= '0;
                ph_r      <= '0;
                if (k_r == 2'd2) begin
                  k_r     <= '0;
                  state_r <= S_SL;
                end else begin
                  k_r <= k_r + 2'd1;
                end
              end else begin
                ph_r <= 3'd3;
              end
            end
            3'd3: begin
              acc_s_r <= acc_s_r + prod_q;
              ph_r    <= 3'd4;
            end
            default: begin
              acc_d_r <= acc_d_r + prod_q;
              c_r     <= c_r + 2'd1;
              ph_r    <= '0;
            end
          endcase
        end
        S_SL: begin
          unique case (ph_r)
            3'd0: begin
              if (ld_r[k_r] == 0) begin
                inv_r <= 32'sh7FFFFFFF;
                ph_r  <= 3'd2;
              end else begin
                ph_r <= 3'd1;
              end
            end
            3'd1: begin
              if (div_done) begin
                inv_r <= sat32(div_quo);
                ph_r  <= 3'd2;
              end
            end
            3'd2: ph_r <= 3'd3;
            3'd3: begin
              ta_r <= prod_q;
              ph_r <= 3'd4;
            end
            default: begin
              if (inv_r < 0) begin
                tn_r[k_r] <= prod_q;
                tf_r[k_r] <= ta_r;
              end else begin
                tn_r[k_r] <= ta_r;
                tf_r[k_r] <= prod_q;
              end
              ph_r <= '0;
              if (k_r == 2'd2) begin
                k_r     <= '0;
                state_r <= S_TEST;
              end else begin
                k_r <= k_r + 2'd1;
              end
            end
          endcase
        end
        S_TEST: begin
          if (slab_hit) begin
            tmin_r  <= tmin2;
            hit_r   <= 1'b1;
            ph_r    <= '0;
            k_r     <= '0;
            state_r <= S_HIT;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_HIT: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            lh_r[k_r] <= sat32(64'(ls_r[k_r]) + prod_q);
            ph_r      <= '0;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              c_r     <= '0;
              acc_s_r <= '0;
              state_r <= S_XF;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_XF: begin
          unique case (ph_r)
            3'd0: ph_r <= 3'd1;
            3'd1: begin
              word_r <= signed'(rdata);
              ph_r   <= 3'd2;
            end
            3'd2: begin
              if (c_r == 2'd3) begin
                wp_r[k_r] <= sat32(acc_s_r + 64'(word_r));
                acc_s_r   <= '0;
                c_r       <= '0;
                ph_r      <= '0;
                if (k_r == 2'd2) begin
                  k_r     <= '0;
                  sq_r    <= '0;
                  state_r <= S_SQ;
                end else begin
                  k_r <= k_r + 2'd1;
                end
              end else begin
                ph_r <= 3'd3;
              end
            end
            default: begin
              acc_s_r <= acc_s_r + prod_q;
              c_r     <= c_r + 2'd1;
              ph_r    <= '0;
            end
          endcase
        end
        S_SQ: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            sq_r <= sq_r + (prod_r[63:0] >> FRAC_BITS);
            ph_r <= '0;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_CMP;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_CMP: begin
          if (sq_r < best_sq_r) begin
            best_sq_r <= sq_r;
            ax_r      <= ax_sel;
            s2_r      <= '0;
            k_r       <= '0;
            ph_r      <= '0;
            state_r   <= S_NRM;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NRM: begin
          unique case (ph_r)
            3'd0: ph_r <= 3'd1;
            3'd1: begin
              v_r[k_r] <= col_v;
              ph_r     <= 3'd2;
            end
            3'd2: ph_r <= 3'd3;
            default: begin
              s2_r <= s2_r + prod_r[63:0];
              ph_r <= '0;
              if (k_r == 2'd2) begin
                k_r     <= '0;
                state_r <= S_SQRT;
              end else begin
                k_r <= k_r + 2'd1;
              end
            end
          endcase
        end
        S_SQRT: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else if (sqrt_done) begin
            mag_r <= sqrt_root;
            ph_r  <= '0;
            k_r   <= '0;
            if (sqrt_root == 32'd0) begin
              for (int i = 0; i < 3; i++) begin
                best_nrm_r[i] <= '0;
                best_pos_r[i] <= wp_r[i];
              end
              state_r <= S_NEXT;
            end else begin
              state_r <= S_DIVN;
            end
          end
        end
        S_DIVN: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else if (div_done) begin
            best_nrm_r[k_r] <= signed'(q_clamp[17:0]);
            ph_r            <= '0;
            if (k_r == 2'd2) begin
              k_r <= '0;
              for (int i = 0; i < 3; i++) begin
                best_pos_r[i] <= wp_r[i];
              end
              state_r <= S_NEXT;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_NEXT: begin
          if (BW'(b_r + 1'b1) == n_r) begin
            state_r <= S_DONE;
          end else begin
            b_r     <= BW'(b_r + 1'b1);
            base_r  <= AW'(base_r + AW'(WORDS_PER_BOX));
            k_r     <= '0;
            c_r     <= '0;
            ph_r    <= '0;
            acc_s_r <= '0;
            acc_d_r <= '0;
            state_r <= S_XI;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_hit_r   <= hit_r;
            for (int i = 0; i < 3; i++) begin
              out_pos_r[i] <= best_pos_r[i];
              out_nrm_r[i] <= best_nrm_r[i];
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  rob_ram #(
    .W(32),
    .D(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_word_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  rob_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_quo)
  );

  rob_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .value(s2_r),
    .done (sqrt_done),
    .root (sqrt_root)
  );

endmodule
`default_nettype wire

>>> sim/tb_ray_oriented_box_nearest_hit_core.sv
// Testbench for the oriented box nearest hit core: loads, rays, register settings, stalls.
`timescale 1ns / 100ps
`default_nettype none
module tb_ray_oriented_box_nearest_hit_core;
  import rob_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RAY  = 1'b1;
  localparam int   NBOX      = 64;
  localparam longint ONE_Q   = 64'sd65536;
  localparam longint EPS_Q   = (ONE_Q + 50000) / 100000;
  localparam int   STALL_LIMIT = 200000;
  localparam logic [2:0] ADDR_BOX_COUNT = 3'(4 * REG_BOX_COUNT);

  typedef struct {
    logic               mode;
    logic [5:0]         box;
    logic [4:0]         widx;
    logic signed [31:0] value;
    logic signed [31:0] start [3];
    logic signed [17:0] dir [3];
    logic [30:0]        len;
  } word_t;

  typedef struct {
    logic        hit;
    logic [31:0] pos [3];
    logic [17:0] nrm [3];
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] in_mode = '0;
  logic [5:0] in_box_index = '0;
  logic [4:0] in_word_index = '0;
  logic signed [31:0] in_word_value = '0;
  logic signed [31:0] in_ray_start_x = '0, in_ray_start_y = '0, in_ray_start_z = '0;
  logic signed [17:0] in_ray_dir_x = '0, in_ray_dir_y = '0, in_ray_dir_z = '0;
  logic [30:0] in_ray_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [0:0] out_any_hit;
  logic signed [31:0] out_hit_pos_x, out_hit_pos_y, out_hit_pos_z;
  logic signed [17:0] out_hit_norm_x, out_hit_norm_y, out_hit_norm_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_oriented_box_nearest_hit_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_box_index(in_box_index), .in_word_index(in_word_index),
    .in_word_value(in_word_value),
    .in_ray_start_x(in_ray_start_x), .in_ray_start_y(in_ray_start_y),
    .in_ray_start_z(in_ray_start_z),
    .in_ray_dir_x(in_ray_dir_x), .in_ray_dir_y(in_ray_dir_y), .in_ray_dir_z(in_ray_dir_z),
    .in_ray_length(in_ray_length),
    .out_valid(out_valid), .out_ready(out_ready), .out_any_hit(out_any_hit),
    .out_hit_pos_x(out_hit_pos_x), .out_hit_pos_y(out_hit_pos_y),
    .out_hit_pos_z(out_hit_pos_z),
    .out_hit_norm_x(out_hit_norm_x), .out_hit_norm_y(out_hit_norm_y),
    .out_hit_norm_z(out_hit_norm_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  int   box_xform [NBOX * WORDS_PER_BOX];
  int   boxes_tested = 0;
  hit_t hits_due [$];
  int   mismatches = 0;
  int   loads_sent = 0, rays_sent = 0, hits_seen = 0, results_seen = 0;
  int   burst_left = 0;
  bit   steady_send = 0;
  bit   long_hold_req = 0;
  int   idle_cycles = 0;

  // box space arithmetic
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint xform_word(int base, int idx);
    return longint'(box_xform[base + idx]);
  endfunction

  function automatic void apply_xform(int base, longint p [3], bit with_trans,
                                      output longint o [3]);
    longint acc;
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += qmul(xform_word(base, r * 4 + c), p[c]);
      if (with_trans) acc += xform_word(base, r * 4 + 3);
      o[r] = clamp32(acc);
    end
  endfunction

  function automatic longint slab_recip(longint d);
    if (d == 0) return 64'sd2147483647;
    return clamp32((64'sd1 <<< 32) / d);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic hit_t nearest_hit(word_t w);
    longint rs [3], rd [3], ls [3], ld [3], tn [3], tf [3], lh [3], wp [3], v [3];
    longint bpos [3], bnrm [3];
    longint len, tmin, tmax, inv, a, c, d, q;
    longint unsigned sq, best_sq, m, s2, mag;
    int n, base, ax;
    bit hit;
    hit_t r;
    hit = 0;
    best_sq = '1;
    for (int k = 0; k < 3; k++) begin
      rs[k] = longint'(w.start[k]);
      rd[k] = longint'(w.dir[k]);
      bpos[k] = 0;
      bnrm[k] = 0;
    end
    len = longint'(w.len);
    n = boxes_tested > NBOX ? NBOX : boxes_tested;
    for (int b = 0; b < n; b++) begin
      base = b * WORDS_PER_BOX;
      apply_xform(base, rs, 1, ls);
      apply_xform(base, rd, 0, ld);
      for (int k = 0; k < 3; k++) begin
        inv = slab_recip(ld[k]);
        a = ((-ONE_Q - ls[k]) * inv) >>> 16;
        c = ((ONE_Q - ls[k]) * inv) >>> 16;
        if (inv < 0) begin
          tn[k] = c; tf[k] = a;
        end else begin
          tn[k] = a; tf[k] = c;
        end
      end
      if (tn[0] > tf[1] || tn[1] > tf[0]) continue;
      tmin = tn[0] > tn[1] ? tn[0] : tn[1];
      tmax = tf[0] < tf[1] ? tf[0] : tf[1];
      if (tmin > tf[2] || tn[2] > tmax) continue;
      if (tn[2] > tmin) tmin = tn[2];
      if (!(EPS_Q < tmin && tmin < len)) continue;
      hit = 1;
      for (int k = 0; k < 3; k++) lh[k] = clamp32(ls[k] + qmul(ld[k], tmin));
      apply_xform(base + FWD_OFFSET, lh, 1, wp);
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        d = wp[k] - rs[k];
        m = longint'(d < 0 ? -d : d);
        sq += (m * m) >> 16;
      end
      if (sq < best_sq) begin
        best_sq = sq;
        if (tn[0] > tn[1] && tn[0] > tn[2]) ax = 0;
        else if (tn[1] > tn[2]) ax = 1;
        else ax = 2;
        s2 = 0;
        for (int k = 0; k < 3; k++) begin
          v[k] = ld[ax] < 0 ? xform_word(base + FWD_OFFSET, k * 4 + ax)
                            : -xform_word(base + FWD_OFFSET, k * 4 + ax);
          m = longint'(v[k] < 0 ? -v[k] : v[k]);
          s2 += m * m;
        end
        mag = int_sqrt(s2);
        for (int k = 0; k < 3; k++) begin
          bpos[k] = wp[k];
          if (mag == 0) begin
            bnrm[k] = 0;
          end else begin
            q = (v[k] * ONE_Q) / longint'(mag);
            if (q > ONE_Q) q = ONE_Q;
            if (q < -ONE_Q) q = -ONE_Q;
            bnrm[k] = q;
          end
        end
      end
    end
    r.hit = hit;
    for (int k = 0; k < 3; k++) begin
      r.pos[k] = hit ? bpos[k][31:0] : '0;
      r.nrm[k] = hit ? bnrm[k][17:0] : '0;
    end
    return r;
  endfunction

  // word generation
  function automatic logic signed [31:0] plausible_entry(int widx);
    int row, col;
    row = (widx % 12) / 4;
    col = widx % 4;
    if (col == 3) return (widx < FWD_OFFSET) ? $signed($urandom_range(0, 262144)) - 131072
                                             : $signed($urandom_range(0, 1048576)) - 524288;
    if (col == row) return $signed($urandom_range(32768, 131072)) *
                           (($urandom % 8 == 0) ? -1 : 1);
    return $signed($urandom_range(0, 16384)) - 8192;
  endfunction

  function automatic word_t load_word(int box, int widx, logic signed [31:0] value);
    word_t w;
    w = '{default: '0, start: '{default: '0}, dir: '{default: '0}};
    w.mode = MODE_LOAD;
    w.box = 6'(box);
    w.widx = 5'(widx);
    w.value = value;
    return w;
  endfunction

  function automatic word_t ray_word(int sx, int sy, int sz, int dx, int dy, int dz, int len);
    word_t w;
    w = '{default: '0, start: '{default: '0}, dir: '{default: '0}};
    w.mode = MODE_RAY;
    w.start = '{sx, sy, sz};
    w.dir = '{18'(dx), 18'(dy), 18'(dz)};
    w.len = 31'(len);
    w.value = $urandom;
    w.box = 6'($urandom);
    w.widx = 5'($urandom);
    return w;
  endfunction

  function automatic word_t random_ray();
    int s [3], dv [3];
    for (int k = 0; k < 3; k++) begin
      s[k] = ($urandom % 10 == 0) ? int'($urandom) : $signed($urandom_range(0, 524288)) - 262144;
      dv[k] = $signed($urandom_range(0, 131072)) - 65536;
    end
    return ray_word(s[0], s[1], s[2], dv[0], dv[1], dv[2],
                    ($urandom % 8 == 0) ? int'($urandom & 32'h7FFFFFFF)
                                        : int'($urandom_range(0, 1048576)));
  endfunction

  // input channel
  task automatic send_word(word_t w);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_mode <= w.mode;
    in_box_index <= w.box;
    in_word_index <= w.widx;
    in_word_value <= w.value;
    in_ray_start_x <= w.start[0];
    in_ray_start_y <= w.start[1];
    in_ray_start_z <= w.start[2];
    in_ray_dir_x <= w.dir[0];
    in_ray_dir_y <= w.dir[1];
    in_ray_dir_z <= w.dir[2];
    in_ray_length <= w.len;
    do @(posedge clk); while (!in_ready);
    if (w.mode == MODE_LOAD) begin
      loads_sent++;
      if (w.widx < WORDS_PER_BOX) box_xform[w.box * WORDS_PER_BOX + w.widx] = w.value;
    end else begin
      rays_sent++;
      hits_due.push_back(nearest_hit(w));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_box_count(int count);
    wait_drained();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BOX_COUNT; pwdata <= 32'(count);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    boxes_tested = count & 8'h7F;
    @(posedge clk);
  endtask

  // result channel
  int rx_phase = 0, rx_pattern = 0, hold_left = 0;
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 256 == 0) rx_pattern <= $urandom % 3;
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= 4000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom % 2);
        default: out_ready <= (rx_phase % 7) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    hit_t e;
    bit bad;
    if (out_valid && out_ready) begin
      results_seen++;
      if (out_any_hit) hits_seen++;
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = hits_due.pop_front();
        bad = (out_any_hit !== e.hit) ||
              (out_hit_pos_x !== e.pos[0]) || (out_hit_pos_y !== e.pos[1]) ||
              (out_hit_pos_z !== e.pos[2]) ||
              (out_hit_norm_x !== e.nrm[0]) || (out_hit_norm_y !== e.nrm[1]) ||
              (out_hit_norm_z !== e.nrm[2]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp hit %0d pos %h %h %h nrm %h %h %h",
                     $realtime, e.hit, e.pos[0], e.pos[1], e.pos[2],
                     e.nrm[0], e.nrm[1], e.nrm[2]);
            $display("  got hit %0d pos %h %h %h nrm %h %h %h", out_any_hit,
                     out_hit_pos_x, out_hit_pos_y, out_hit_pos_z,
                     out_hit_norm_x, out_hit_norm_y, out_hit_norm_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // tests
  task automatic test_load_all_boxes();
    for (int b = 0; b < NBOX; b++)
      for (int wi = 0; wi < WORDS_PER_BOX; wi++) send_word(load_word(b, wi, plausible_entry(wi)));
    // unit cube at origin, and a shifted cube whose forward transform is all zero
    for (int wi = 0; wi < WORDS_PER_BOX; wi++) begin
      send_word(load_word(0, wi, (wi % 12 == 0 || wi % 12 == 5 || wi % 12 == 10) ?
                                 32'(ONE_Q) : 32'sd0));
      send_word(load_word(1, wi, (wi < FWD_OFFSET && wi % 5 == 0) ? 32'(ONE_Q)
                               : (wi == 3 ? 32'(-5 * ONE_Q) : 32'sd0)));
    end
  endtask

  task automatic test_directed_rays();
    set_box_count(0);
    send_word(ray_word(-3 * 65536, 0, 0, 65536, 0, 0, 10 * 65536));
    set_box_count(2);
    send_word(ray_word(-3 * 65536, 0, 0, 65536, 0, 0, 20 * 65536));
    send_word(ray_word(9 * 65536, 0, 0, -65536, 0, 0, 20 * 65536));
    send_word(ray_word(-3 * 65536, -3 * 65536, -3 * 65536, 65536, 65536, 65536, 32'h7FFFFFFF));
    send_word(ray_word(0, -3 * 65536, 0, 0, 65536, 0, 0));
    send_word(ray_word(0, 0, 3 * 65536, 0, 0, -65536, 100 * 65536));
    send_word(ray_word(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
    send_word(ray_word(32'h80000000, 32'h7FFFFFFF, 32'h80000000, -65536, 65536, -65536,
                       32'h7FFFFFFF));
    send_word(ray_word(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 65536, -65536, 65536,
                       32'h7FFFFFFF));
    send_word(ray_word(5 * 65536, -4 * 65536, 0, 0, 65536, 0, 30 * 65536));
    send_word(load_word(2, 24, 32'h7FFFFFFF));
    send_word(load_word(2, 31, 32'h80000000));
  endtask

  task automatic test_box_count_extremes();
    set_box_count(64);
    send_word(random_ray());
    send_word(ray_word(-3 * 65536, 0, 0, 65536, 0, 0, 20 * 65536));
    set_box_count(127);
    send_word(random_ray());
  endtask

  task automatic test_output_backpressure();
    set_box_count(1);
    long_hold_req = 1'b1;
    steady_send = 1;
    for (int i = 0; i < 6; i++) send_word(random_ray());
    steady_send = 0;
  endtask

  task automatic test_drain_pause();
    set_box_count(3);
    for (int i = 0; i < 4; i++) send_word(random_ray());
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) send_word(random_ray());
  endtask

  task automatic test_random_traffic();
    int pick, b, wi;
    for (int phase = 0; phase < 10; phase++) begin
      set_box_count(($urandom % 6 == 0) ? 0 : $urandom_range(1, 4));
      steady_send = (phase % 3 == 2);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom % 100;
        if (pick < 70) begin
          b = ($urandom % 4 == 0) ? $urandom_range(0, NBOX - 1) : $urandom_range(0, 4);
          wi = $urandom_range(0, WORDS_PER_BOX - 1);
          send_word(load_word(b, wi, plausible_entry(wi)));
        end else if (pick < 78) begin
          send_word(load_word($urandom_range(0, NBOX - 1), $urandom_range(0, 31), $urandom));
        end else begin
          send_word(random_ray());
        end
      end
    end
    steady_send = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_all_boxes();
    test_directed_rays();
    test_box_count_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d transform loads and %0d rays, %0d results with %0d hits",
             loads_sent, rays_sent, results_seen, hits_seen);
    $display("box counts 0 to 127, long output hold-off, drain pause; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
